[src/roman_numeral_encoder_unit_defines.svh]
// ----------------------------------------------------------------------------
// roman_numeral_encoder_unit_defines.svh
// Assertion macros shared by the checker. clk and rst must be in scope.
// ----------------------------------------------------------------------------
`ifndef ROMAN_NUMERAL_ENCODER_UNIT_DEFINES_SVH
`define ROMAN_NUMERAL_ENCODER_UNIT_DEFINES_SVH

// concurrent check, off while reset is high
`define RNE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check that also holds across reset
`define RNE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/rne_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rne_pkg
// Types, constants and the digit pattern table of the Roman numeral encoder.
// ----------------------------------------------------------------------------
package rne_pkg;

  localparam int VALUE_W     = 16;
  localparam int REM_W       = 12;
  localparam int LETTER_W    = 7;
  localparam int MAX_LETTERS = 15;
  localparam int COUNT_W     = 4;
  localparam int BUF_W       = LETTER_W * MAX_LETTERS;
  localparam int PAT_W       = LETTER_W * 4;
  localparam int MAX_VALUE   = 3999;

  localparam logic [LETTER_W-1:0] CH_NONE = 7'd0;
  localparam logic [LETTER_W-1:0] CH_I    = 7'd73;
  localparam logic [LETTER_W-1:0] CH_V    = 7'd86;
  localparam logic [LETTER_W-1:0] CH_X    = 7'd88;
  localparam logic [LETTER_W-1:0] CH_L    = 7'd76;
  localparam logic [LETTER_W-1:0] CH_C    = 7'd67;
  localparam logic [LETTER_W-1:0] CH_D    = 7'd68;
  localparam logic [LETTER_W-1:0] CH_M    = 7'd77;

  // letters are packed first letter in the low bits
  typedef struct packed {
    logic [REM_W-1:0]   rem;
    logic [BUF_W-1:0]   letters;
    logic [COUNT_W-1:0] count;
    logic               oor;
  } rne_item_t;

  typedef struct packed {
    logic [PAT_W-1:0] pat;
    logic [2:0]       len;
  } rne_pat_t;

  // one decimal digit in terms of its one, five and ten letters
  function automatic rne_pat_t digit_pattern(input logic [3:0] d,
                                             input logic [LETTER_W-1:0] one,
                                             input logic [LETTER_W-1:0] five,
                                             input logic [LETTER_W-1:0] ten);
    rne_pat_t p;
    p.pat = '0;
    p.len = 3'd0;
    case (d)
      4'd1: begin p.pat = {21'b0, one};              p.len = 3'd1; end
      4'd2: begin p.pat = {14'b0, one, one};         p.len = 3'd2; end
      4'd3: begin p.pat = {7'b0, one, one, one};     p.len = 3'd3; end
      4'd4: begin p.pat = {14'b0, five, one};        p.len = 3'd2; end
      4'd5: begin p.pat = {21'b0, five};             p.len = 3'd1; end
      4'd6: begin p.pat = {14'b0, one, five};        p.len = 3'd2; end
      4'd7: begin p.pat = {7'b0, one, one, five};    p.len = 3'd3; end
      4'd8: begin p.pat = {one, one, one, five};     p.len = 3'd4; end
      4'd9: begin p.pat = {14'b0, ten, one};         p.len = 3'd2; end
      default: begin p.pat = '0;                     p.len = 3'd0; end
    endcase
    return p;
  endfunction

endpackage

[src/rne_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rne_stage
// One decimal place: pulls the digit out of the remainder, appends its letters.
// ----------------------------------------------------------------------------
module rne_stage #(
  parameter int                              Unit = 1,
  parameter logic [rne_pkg::LETTER_W-1:0]    One  = rne_pkg::CH_I,
  parameter logic [rne_pkg::LETTER_W-1:0]    Five = rne_pkg::CH_V,
  parameter logic [rne_pkg::LETTER_W-1:0]    Ten  = rne_pkg::CH_X
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rne_pkg::rne_item_t in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output rne_pkg::rne_item_t out_item
);
  import rne_pkg::*;

  logic              valid;
  rne_item_t         item;
  rne_item_t         item_next;
  logic [3:0]        digit;
  logic [13:0]       sub;
  rne_pat_t          pat;
  logic [6:0]        shamt;
  logic              hold;

  assign hold     = valid && out_stall;
  assign in_stall = hold;

  always_comb begin
    digit = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if ({2'b0, in_item.rem} >= 14'(Unit * k)) begin
        digit = 4'(k);
      end
    end
    sub   = 14'(Unit) * {10'b0, digit};
    pat   = digit_pattern(digit, One, Five, Ten);
    shamt = 7'(in_item.count) * 7'(LETTER_W);
    item_next.rem     = in_item.rem - sub[REM_W-1:0];
    item_next.letters = in_item.letters | (BUF_W'(pat.pat) << shamt);
    item_next.count   = in_item.count + {1'b0, pat.len};
    item_next.oor     = in_item.oor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!hold) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      item <= item_next;
    end
  end

  assign out_valid = valid;
  assign out_item  = item;

endmodule

[src/rne_serial.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rne_serial
// Output shifter: sends the assembled numeral one letter per beat.
// ----------------------------------------------------------------------------
module rne_serial (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rne_pkg::rne_item_t in_item,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [6:0]         letter,
  output logic               out_of_range,
  output logic               last
);
  import rne_pkg::*;

  logic                 valid;
  logic [BUF_W-1:0]     sbuf;
  logic [COUNT_W-1:0]   scnt;
  logic                 soor;
  logic                 is_last;
  logic                 free;

  assign is_last  = (scnt == 4'd1);
  assign free     = !valid || (!result_stall && is_last);
  assign in_stall = !free;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free) begin
      soor <= in_item.oor;
      if (in_item.oor || in_item.count == 4'd0) begin
        sbuf <= '0;
        scnt <= 4'd1;
      end else begin
        sbuf <= in_item.letters;
        scnt <= in_item.count;
      end
    end else if (!result_stall) begin
      sbuf <= sbuf >> LETTER_W;
      scnt <= scnt - 4'd1;
    end
  end

  assign result_valid = valid;
  assign letter       = sbuf[LETTER_W-1:0];
  assign out_of_range = soor;
  assign last         = is_last;

endmodule

[src/roman_numeral_encoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roman_numeral_encoder_unit
// Binary to Roman numeral converter, one ASCII letter per output beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid/item_stall) takes one 16-bit value per beat.
//   Output channel (result_valid/result_stall) returns the numeral letters,
//   most significant first, with last set on the final letter of a value.
//   Zero gives one beat with letter 0 and last set (the empty numeral).
//   Values above 3999 give one beat with letter 0, out_of_range and last set.
// Pipeline: the thousands stage, with the range check in front, loads on
//   the edge that takes the value; the hundreds, tens and ones stages and
//   the shifter follow in turn, each registered, and any of them can stall.
// Throughput: the output shifter sends one letter per cycle unless stalled,
//   so a value holds the output for one beat per letter of its numeral
//   (1 to 15, 15 for 3888). Values behind it wait in the four digit stages,
//   which accept a new value every cycle while they have room.
// Stall: result_stall freezes the current letter; the back-pressure walks
//   up the stages and raises item_stall once they are all full.
// Reset: synchronous, clears every valid bit; nothing in flight survives.
// ----------------------------------------------------------------------------
module roman_numeral_encoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [15:0] value,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [6:0]  letter,
  output logic        out_of_range,
  output logic        last
);
  import rne_pkg::*;

  rne_item_t front;
  rne_item_t s1_item, s2_item, s3_item, s4_item;
  logic      s1_valid, s2_valid, s3_valid, s4_valid;
  logic      s1_stall, s2_stall, s3_stall, s4_stall, ser_stall;

  // range check in front of the thousands stage; an error carries rem 0
  always_comb begin
    front.oor     = (value > VALUE_W'(MAX_VALUE));
    front.rem     = front.oor ? '0 : value[REM_W-1:0];
    front.letters = '0;
    front.count   = '0;
  end

  assign item_stall = s1_stall;

  rne_stage #(.Unit(1000), .One(CH_M), .Five(CH_NONE), .Ten(CH_NONE)) u_thou (
    .clk(clk), .rst(rst),
    .in_valid(item_valid), .in_stall(s1_stall), .in_item(front),
    .out_valid(s1_valid), .out_stall(s2_stall), .out_item(s1_item)
  );

  rne_stage #(.Unit(100), .One(CH_C), .Five(CH_D), .Ten(CH_M)) u_hund (
    .clk(clk), .rst(rst),
    .in_valid(s1_valid), .in_stall(s2_stall), .in_item(s1_item),
    .out_valid(s2_valid), .out_stall(s3_stall), .out_item(s2_item)
  );

  rne_stage #(.Unit(10), .One(CH_X), .Five(CH_L), .Ten(CH_C)) u_tens (
    .clk(clk), .rst(rst),
    .in_valid(s2_valid), .in_stall(s3_stall), .in_item(s2_item),
    .out_valid(s3_valid), .out_stall(s4_stall), .out_item(s3_item)
  );

  rne_stage #(.Unit(1), .One(CH_I), .Five(CH_V), .Ten(CH_X)) u_ones (
    .clk(clk), .rst(rst),
    .in_valid(s3_valid), .in_stall(s4_stall), .in_item(s3_item),
    .out_valid(s4_valid), .out_stall(ser_stall), .out_item(s4_item)
  );

  rne_serial u_ser (
    .clk(clk), .rst(rst),
    .in_valid(s4_valid), .in_stall(ser_stall), .in_item(s4_item),
    .result_valid(result_valid), .result_stall(result_stall),
    .letter(letter), .out_of_range(out_of_range), .last(last)
  );

endmodule

[src/rne_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rne_checker
// Port-level checks on the encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "roman_numeral_encoder_unit_defines.svh"

module rne_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_stall,
  input logic [15:0] value,
  input logic        result_valid,
  input logic        result_stall,
  input logic [6:0]  letter,
  input logic        out_of_range,
  input logic        last
);

  // error beat stands alone and carries no letter
  `RNE_ASSERT(a_oor_single, result_valid && out_of_range |-> last && letter == 7'd0, "oor beat not single")

  // an empty letter only ever ends a run
  `RNE_ASSERT(a_zero_last, result_valid && letter == 7'd0 |-> last, "empty letter mid-run")

  // stalled beat holds
  `RNE_ASSERT(a_hold, result_valid && result_stall |=> result_valid && $stable(letter) && $stable(last) && $stable(out_of_range), "stalled beat changed")

  // stalled input beat holds
  `RNE_ASSERT(a_in_hold, item_valid && item_stall |=> item_valid && $stable(value), "stalled input beat changed")

  // reset flushes the output
  `RNE_ASSERT_RST(a_rst_flush, rst |=> !result_valid, "valid after reset")

endmodule

bind roman_numeral_encoder_unit rne_checker u_rne_checker (.*);
